@@ hdl/adaptive_envelope_trigger_assert.svh @@
// Assertion macros for the adaptive envelope trigger.
// Depends on nothing; expects signals clk and arst_n in the including module.
`ifndef ADAPTIVE_ENVELOPE_TRIGGER_ASSERT_SVH
`define ADAPTIVE_ENVELOPE_TRIGGER_ASSERT_SVH
`ifndef SYNTHESIS
// Same-cycle implication, checked on every rising clock edge out of reset.
`define AET_ASSERT_NOW(name, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("assertion failed: same-cycle rule");
// Next-cycle implication.
`define AET_ASSERT_NEXT(name, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("assertion failed: next-cycle rule");
`else
`define AET_ASSERT_NOW(name, ante, cons)
`define AET_ASSERT_NEXT(name, ante, cons)
`endif
`endif

@@ hdl/aet_pkg.sv @@
// Shared constants and types of the adaptive envelope trigger.
// Depends on nothing; used by aet_envelope and adaptive_envelope_trigger.
package aet_pkg;

	localparam int SAMPLE_BITS_DEFAULT = 10;
	localparam int HOLD_BITS = 16;
	localparam logic [HOLD_BITS-1:0] HOLD_TICKS_RESET = 16'd200;

	localparam int APB_ADDR_BITS = 3;
	localparam int APB_DATA_BITS = 32;
	localparam logic [APB_ADDR_BITS-1:0] ADDR_HOLD_TICKS = 3'h0;

	localparam int FLAGS_BITS = 3;
	localparam int FLAG_LOW = 0;
	localparam int FLAG_HIGH = 1;
	localparam int FLAG_ACTIVE = 2;

	localparam int TELE_BITS = 8;
	// low, high, active, telemetry byte, padded to whole bytes
	localparam int OUT_TDATA_BITS = ((FLAGS_BITS + TELE_BITS + 7) / 8) * 8;

	typedef struct packed {
		logic below;
		logic above;
	} aet_excursion_t;

endpackage

@@ hdl/aet_envelope.sv @@
// Running mean and upper/lower envelope trackers with the excursion compare.
// Depends on aet_pkg.
module aet_envelope import aet_pkg::*; #(
	parameter int SAMPLE_BITS = SAMPLE_BITS_DEFAULT
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   update,
	input  logic [SAMPLE_BITS-1:0] sample,
	output aet_excursion_t         excursion
);

	localparam int ACC_BITS = SAMPLE_BITS + 6;
	localparam logic [ACC_BITS-1:0] ROUND32 = ACC_BITS'(16);
	localparam logic [ACC_BITS-1:0] ROUND16 = ACC_BITS'(8);

	typedef logic [SAMPLE_BITS-1:0] level_t;
	typedef logic [ACC_BITS-1:0] acc_t;

	// (target + 31*level + 16) >> 5
	function automatic level_t blend32(level_t target, level_t level);
		acc_t acc;
		acc = acc_t'(target) + (acc_t'(level) << 5) - acc_t'(level) + ROUND32;
		return acc[SAMPLE_BITS+4:5];
	endfunction

	// (target + 15*level + 8) >> 4
	function automatic level_t blend16(level_t target, level_t level);
		acc_t acc;
		acc = acc_t'(target) + (acc_t'(level) << 4) - acc_t'(level) + ROUND16;
		return acc[SAMPLE_BITS+3:4];
	endfunction

	level_t mean_q, upper_q, lower_q;
	level_t mean_n, upper_n, lower_n;

	always_comb begin
		mean_n  = blend32(sample, mean_q);
		upper_n = upper_q;
		lower_n = lower_q;
		if (sample > mean_n) begin
			upper_n = blend16(sample, upper_q);
		end else if (sample < mean_n) begin
			lower_n = blend16(sample, lower_q);
		end else begin
			upper_n = blend32(mean_n, upper_q);
			lower_n = blend32(mean_n, lower_q);
		end
		excursion.below = sample < lower_n;
		excursion.above = sample > upper_n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mean_q  <= {1'b0, {(SAMPLE_BITS-1){1'b1}}};
			upper_q <= '0;
			lower_q <= '1;
		end else if (update) begin
			mean_q  <= mean_n;
			upper_q <= upper_n;
			lower_q <= lower_n;
		end
	end

endmodule

@@ hdl/adaptive_envelope_trigger.sv @@
// Adaptive envelope trigger: an input transfer passes through the input register, then
// the result register, to the output port; one item per cycle unless the output stalls.
// The tracker state is updated as the item leaves the input register, so the next
// item can follow in the very next cycle.
// Reset (arst_n low, asynchronous) empties both registers, sets the mean to half scale,
// the envelopes to zero and full scale, clears flags and hold, and loads hold_ticks 200.
`include "adaptive_envelope_trigger_assert.svh"
module adaptive_envelope_trigger import aet_pkg::*; #(
	parameter int SAMPLE_BITS = SAMPLE_BITS_DEFAULT
) (
	input  logic                      clk,
	input  logic                      arst_n,
	// Input stream.
	input  logic                      s_axis_tvalid,
	output logic                      s_axis_tready,
	// tdata from bit 0 up: sample, tick, zero padding.
	input  logic [((SAMPLE_BITS+8)/8)*8-1:0] s_axis_tdata,
	// tuser: sample_valid.
	input  logic                      s_axis_tuser,
	// Result stream.
	output logic                      m_axis_tvalid,
	input  logic                      m_axis_tready,
	// tdata from bit 0 up: low_event, high_event, active, telemetry_byte, zero padding.
	output logic [OUT_TDATA_BITS-1:0] m_axis_tdata,
	// tuser: telemetry_valid.
	output logic                      m_axis_tuser,
	// Configuration port.
	input  logic                      psel,
	input  logic                      penable,
	input  logic                      pwrite,
	input  logic [APB_ADDR_BITS-1:0]  paddr,
	input  logic [APB_DATA_BITS-1:0]  pwdata,
	output logic [APB_DATA_BITS-1:0]  prdata,
	output logic                      pready
);

	// Configuration register. Writes complete in the access cycle; reads return
	// the register zero-extended, and unused addresses read as zero.
	logic [HOLD_BITS-1:0] hold_ticks_q;

	assign pready = 1'b1;
	assign prdata = (paddr == ADDR_HOLD_TICKS) ?
		{{(APB_DATA_BITS-HOLD_BITS){1'b0}}, hold_ticks_q} : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_ticks_q <= HOLD_TICKS_RESET;
		end else if (psel && penable && pwrite && pready && paddr == ADDR_HOLD_TICKS) begin
			hold_ticks_q <= pwdata[HOLD_BITS-1:0];
		end
	end

	// Input register. It takes a new transfer whenever it is empty or its item
	// moves on to the result register in the same cycle.
	logic                   valid_s1;
	logic                   sample_valid_s1;
	logic [SAMPLE_BITS-1:0] sample_s1;
	logic                   tick_s1;
	logic                   advance;
	logic                   out_valid_q;

	assign advance       = valid_s1 && (!out_valid_q || m_axis_tready);
	assign s_axis_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			sample_valid_s1 <= s_axis_tuser;
			sample_s1       <= s_axis_tdata[SAMPLE_BITS-1:0];
			tick_s1         <= s_axis_tdata[SAMPLE_BITS];
		end
	end

	// Mean and envelope tracking. The trackers only move on items that carry
	// a sample.
	aet_excursion_t excursion;

	aet_envelope #(
		.SAMPLE_BITS(SAMPLE_BITS)
	) u_envelope (
		.clk       (clk),
		.arst_n    (arst_n),
		.update    (advance && sample_valid_s1),
		.sample    (sample_s1),
		.excursion (excursion)
	);

	// Hold counter and flags. The tick is applied first and saturates at zero;
	// an excursion in the same item then reloads the counter. A quiet sample
	// clears low and high, and drops active only once the counter is zero.
	logic [HOLD_BITS-1:0]  hold_q, hold_dec, hold_n;
	logic [FLAGS_BITS-1:0] flags_q, flags_n;
	logic                  reload;

	always_comb begin
		hold_dec = (tick_s1 && hold_q != '0) ? hold_q - 1'b1 : hold_q;
		hold_n   = hold_dec;
		flags_n  = flags_q;
		reload   = 1'b0;
		if (sample_valid_s1) begin
			flags_n = '0;
			if (excursion.below) begin
				flags_n[FLAG_LOW]    = 1'b1;
				flags_n[FLAG_ACTIVE] = 1'b1;
				reload               = 1'b1;
			end else if (excursion.above) begin
				flags_n[FLAG_HIGH]   = 1'b1;
				flags_n[FLAG_ACTIVE] = 1'b1;
				reload               = 1'b1;
			end else begin
				flags_n[FLAG_ACTIVE] = flags_q[FLAG_ACTIVE] && hold_dec != '0;
			end
			if (reload) begin
				hold_n = hold_ticks_q;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_q  <= '0;
			flags_q <= '0;
		end else if (advance) begin
			hold_q  <= hold_n;
			flags_q <= flags_n;
		end
	end

	// Result register. Telemetry carries the top eight sample bits, or zero
	// when the item had no sample.
	logic [OUT_TDATA_BITS-1:0] out_data_q;
	logic                      out_tele_valid_q;
	logic [TELE_BITS-1:0]      tele_byte;

	assign tele_byte = sample_valid_s1 ? sample_s1[SAMPLE_BITS-1 -: TELE_BITS] : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			out_data_q <= {{(OUT_TDATA_BITS-FLAGS_BITS-TELE_BITS){1'b0}},
				tele_byte, flags_n};
			out_tele_valid_q <= sample_valid_s1;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;
	assign m_axis_tuser  = out_tele_valid_q;

	// Low and high never stand together, and either implies active.
	`AET_ASSERT_NOW(a_flags_consistent, flags_q[FLAG_LOW] || flags_q[FLAG_HIGH], flags_q[FLAG_ACTIVE] && !(flags_q[FLAG_LOW] && flags_q[FLAG_HIGH]))
	// The hold counter only grows through a reload from the register.
	`AET_ASSERT_NEXT(a_hold_no_growth, advance && !reload, hold_q <= $past(hold_q))
	// An item in the input register is never dropped while the output stalls.
	`AET_ASSERT_NEXT(a_s1_kept, valid_s1 && !advance, valid_s1 && $stable(sample_s1))

endmodule
